FILE: sv/xpfr_pkg.sv
// shared types, constants and helpers for the xor parity fec frame recovery core
// no dependencies; imported by every module of the block

package xpfr_pkg;

	localparam int WINDOW        = 1024;
	localparam int FRAME_W       = $clog2(WINDOW);
	localparam int PAYLOAD_WORDS = 20;
	localparam int WIDX_W        = 5;
	localparam int WL_DEPTH      = 64;
	localparam int WL_AW         = $clog2(WL_DEPTH);
	localparam int MAX_RESULTS   = 64;
	localparam int RES_AW        = $clog2(MAX_RESULTS);
	localparam int CNT_W         = RES_AW + 1;
	localparam int COPY_MAX      = 7;
	localparam int PARITY_MIN    = 8;
	localparam int PARITY_MAX    = 13;
	localparam int SPREAD_OFFSET = 6;
	localparam int PROBE_SPAN    = 7;
	localparam int FST_DEPTH     = WINDOW * PAYLOAD_WORDS;
	localparam int FST_AW        = $clog2(FST_DEPTH);

	typedef enum logic [1:0] {
		CMD_LOAD   = 2'd0,
		CMD_COMMIT = 2'd1,
		CMD_READ   = 2'd2,
		CMD_RSVD   = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [1:0]  command;
		logic [31:0] packet_seq;
		logic [7:0]  packet_flags;
		logic        has_primary;
		logic        has_aux;
		logic [4:0]  word_index;
		logic [63:0] primary_word;
		logic [63:0] aux_word;
	} in_req_t;

	typedef struct packed {
		logic         result_kind;
		logic [9:0]   frame_number;
		logic [63:0]  data_word;
		logic         last_result;
		logic         recovery_truncated;
	} out_res_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_CLEAR,
		OP_CAPTURE,
		OP_RD_ISSUE,
		OP_KN_SEQ,
		OP_KN_AUX,
		OP_TGT_PRIM,
		OP_TGT_AUX,
		OP_COPY,
		OP_ACCEPT,
		OP_ACCEPT_DEC,
		OP_PAR_SEQ,
		OP_IDX_CLR,
		OP_PWR,
		OP_PAR_SET,
		OP_PROBE,
		OP_KN_A,
		OP_KN_B,
		OP_PAR_CLR,
		OP_OVF,
		OP_DEC_SETUP,
		OP_DEC_RD,
		OP_DEC_WR,
		OP_NEXT_K,
		OP_POP,
		OP_LOAD_F,
		OP_EM_RD,
		OP_EM_NEXT
	} dp_op_t;

	typedef struct packed {
		logic clr_last;
		logic prim_ok;
		logic copy_ok;
		logic par_ok;
		logic kn_rd;
		logic pend;
		logic probe_ok;
		logic kn_eq;
		logic kn_a;
		logic res_full;
		logic idx_last;
		logic k_last;
		logic casc;
		logic sp_zero;
		logic ovf;
		logic res_zero;
		logic em_last;
	} dp_status_t;

	function automatic logic [FST_AW-1:0] word_addr(input logic [FRAME_W-1:0] f,
		input logic [WIDX_W-1:0] i);
		word_addr = FST_AW'(f) * FST_AW'(PAYLOAD_WORDS) + FST_AW'(i);
	endfunction

endpackage

FILE: sv/xpfr_datapath.sv
// datapath: staging words, frame and parity stores, flag memories, worklist, result list
// depends on xpfr_pkg; driven by operation codes from xpfr_ctrl

module xpfr_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  xpfr_pkg::in_req_t    req,
	input  xpfr_pkg::dp_op_t     op,
	output xpfr_pkg::dp_status_t st,
	output xpfr_pkg::out_res_t   res_data
);
	import xpfr_pkg::*;

	// captured request and working registers
	in_req_t              req_q;
	logic [FRAME_W-1:0]   tgt_q;
	logic [FRAME_W-1:0]   have_q;
	logic                 src_aux_q;
	logic [FRAME_W-1:0]   fcur_q;
	logic [2:0]           k_q;
	logic                 casc_q;
	logic [WIDX_W-1:0]    idx_q;
	logic [CNT_W-1:0]     res_cnt_q;
	logic [CNT_W-1:0]     sp_q;
	logic                 ovf_q;
	logic                 kn_a_q;
	logic [2:0]           spread_q;
	logic [RES_AW-1:0]    em_q;
	logic [FRAME_W-1:0]   clr_q;

	// storage
	logic [63:0]          stg_prim_q [PAYLOAD_WORDS];
	logic [63:0]          stg_aux_q  [PAYLOAD_WORDS];
	logic [63:0]          fst_mem    [FST_DEPTH];
	logic [63:0]          pst_mem    [FST_DEPTH];
	logic                 kn_mem     [WINDOW];
	logic [3:0]           par_mem    [WINDOW];
	logic [FRAME_W-1:0]   wl_mem     [WL_DEPTH];
	logic [FRAME_W-1:0]   rl_mem     [MAX_RESULTS];

	logic [63:0]          fst_rd_q;
	logic [63:0]          pst_rd_q;
	logic                 kn_rd_q;
	logic [3:0]           par_rd_q;
	logic [FRAME_W-1:0]   wl_rd_q;
	logic [FRAME_W-1:0]   rl_rd_q;

	// derived values
	logic [31:0]          aux_diff;
	logic [7:0]           spr8;
	logic [2:0]           spread_w;
	logic [FRAME_W:0]     p_w;
	logic [FRAME_W-1:0]   p_f;
	logic [FRAME_W-1:0]   a_f;
	logic [FRAME_W-1:0]   b_f;
	logic [FRAME_W-1:0]   seq_f;
	logic                 seq_in;

	// memory port controls
	logic                 fst_we, fst_re, pst_we, pst_re;
	logic [FST_AW-1:0]    fst_wa, fst_ra, pst_wa, pst_ra;
	logic [63:0]          fst_wd;
	logic                 kn_we, kn_re, par_we, par_re;
	logic [FRAME_W-1:0]   kn_wa, kn_ra, par_wa, par_ra;
	logic                 kn_wd;
	logic [3:0]           par_wd;

	assign aux_diff = req_q.packet_seq - 32'(req_q.packet_flags);
	assign spr8     = req_q.packet_flags - 8'(SPREAD_OFFSET);
	assign spread_w = spr8[2:0];
	assign seq_f    = req_q.packet_seq[FRAME_W-1:0];
	assign seq_in   = req_q.packet_seq < 32'(WINDOW);
	assign p_w      = casc_q ? ({1'b0, fcur_q} + (FRAME_W+1)'(k_q)) : {1'b0, seq_f};
	assign p_f      = p_w[FRAME_W-1:0];
	assign a_f      = p_f - FRAME_W'(1);
	assign b_f      = p_f - FRAME_W'(spread_q);

	always_comb begin
		fst_we = 1'b0;
		fst_re = 1'b0;
		pst_we = 1'b0;
		pst_re = 1'b0;
		fst_wa = word_addr(tgt_q, idx_q);
		fst_ra = word_addr(have_q, idx_q);
		pst_wa = word_addr(seq_f, idx_q);
		pst_ra = word_addr(p_f, idx_q);
		fst_wd = src_aux_q ? stg_aux_q[idx_q] : stg_prim_q[idx_q];
		kn_we  = 1'b0;
		kn_re  = 1'b0;
		kn_wa  = tgt_q;
		kn_wd  = 1'b1;
		kn_ra  = seq_f;
		par_we = 1'b0;
		par_re = 1'b0;
		par_wa = p_f;
		par_wd = {1'b0, spread_q};
		par_ra = p_f;
		case (op)
			OP_CLEAR: begin
				kn_we  = 1'b1;
				kn_wa  = clr_q;
				kn_wd  = 1'b0;
				par_we = 1'b1;
				par_wa = clr_q;
				par_wd = 4'd0;
			end
			OP_RD_ISSUE: begin
				kn_re  = 1'b1;
				fst_re = 1'b1;
				fst_ra = word_addr(seq_f, req_q.word_index);
			end
			OP_KN_SEQ: kn_re = 1'b1;
			OP_KN_AUX: begin
				kn_re = 1'b1;
				kn_ra = aux_diff[FRAME_W-1:0];
			end
			OP_COPY: fst_we = 1'b1;
			OP_ACCEPT: kn_we = 1'b1;
			OP_ACCEPT_DEC: begin
				kn_we  = 1'b1;
				par_we = 1'b1;
			end
			OP_PAR_SEQ: begin
				par_re = 1'b1;
				par_ra = seq_f;
			end
			OP_PWR: pst_we = 1'b1;
			OP_PAR_SET: begin
				par_we = 1'b1;
				par_wa = seq_f;
				par_wd = {1'b1, spread_w};
			end
			OP_PROBE: par_re = 1'b1;
			OP_KN_A: begin
				kn_re = 1'b1;
				kn_ra = a_f;
			end
			OP_KN_B: begin
				kn_re = 1'b1;
				kn_ra = b_f;
			end
			OP_PAR_CLR: par_we = 1'b1;
			OP_DEC_RD: begin
				fst_re = 1'b1;
				pst_re = 1'b1;
			end
			OP_DEC_WR: begin
				fst_we = 1'b1;
				fst_wd = fst_rd_q ^ pst_rd_q;
			end
			default: ;
		endcase
	end

	// memories
	always_ff @(posedge clk) begin
		if (fst_we)
			fst_mem[fst_wa] <= fst_wd;
		if (fst_re)
			fst_rd_q <= fst_mem[fst_ra];
	end

	always_ff @(posedge clk) begin
		if (pst_we)
			pst_mem[pst_wa] <= stg_aux_q[idx_q];
		if (pst_re)
			pst_rd_q <= pst_mem[pst_ra];
	end

	always_ff @(posedge clk) begin
		if (kn_we)
			kn_mem[kn_wa] <= kn_wd;
		if (kn_re)
			kn_rd_q <= kn_mem[kn_ra];
	end

	always_ff @(posedge clk) begin
		if (par_we)
			par_mem[par_wa] <= par_wd;
		if (par_re)
			par_rd_q <= par_mem[par_ra];
	end

	always_ff @(posedge clk) begin
		if (op == OP_ACCEPT || op == OP_ACCEPT_DEC)
			wl_mem[sp_q[WL_AW-1:0]] <= tgt_q;
		if (op == OP_POP)
			wl_rd_q <= wl_mem[WL_AW'(sp_q - CNT_W'(1))];
	end

	always_ff @(posedge clk) begin
		if (op == OP_ACCEPT || op == OP_ACCEPT_DEC)
			rl_mem[res_cnt_q[RES_AW-1:0]] <= tgt_q;
		if (op == OP_EM_RD)
			rl_rd_q <= rl_mem[em_q];
	end

	// staging words
	always_ff @(posedge clk) begin
		if (op == OP_CAPTURE && req.command == CMD_LOAD &&
			32'(req.word_index) < 32'(PAYLOAD_WORDS)) begin
			stg_prim_q[req.word_index] <= req.primary_word;
			stg_aux_q[req.word_index]  <= req.aux_word;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (op)
			OP_CAPTURE: req_q <= req;
			OP_TGT_PRIM: tgt_q <= seq_f;
			OP_TGT_AUX: tgt_q <= aux_diff[FRAME_W-1:0];
			OP_KN_A: spread_q <= par_rd_q[2:0];
			OP_KN_B: kn_a_q <= kn_rd_q;
			OP_DEC_SETUP: begin
				tgt_q  <= kn_a_q ? b_f : a_f;
				have_q <= kn_a_q ? a_f : b_f;
			end
			OP_LOAD_F: fcur_q <= wl_rd_q;
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_aux_q <= 1'b0;
			k_q       <= '0;
			casc_q    <= 1'b0;
			idx_q     <= '0;
			res_cnt_q <= '0;
			sp_q      <= '0;
			ovf_q     <= 1'b0;
			em_q      <= '0;
			clr_q     <= '0;
		end else begin
			case (op)
				OP_CLEAR: clr_q <= clr_q + FRAME_W'(1);
				OP_CAPTURE: begin
					res_cnt_q <= '0;
					sp_q      <= '0;
					ovf_q     <= 1'b0;
					em_q      <= '0;
					casc_q    <= 1'b0;
				end
				OP_TGT_PRIM: begin
					src_aux_q <= 1'b0;
					idx_q     <= '0;
				end
				OP_TGT_AUX: begin
					src_aux_q <= 1'b1;
					idx_q     <= '0;
				end
				OP_COPY, OP_PWR, OP_DEC_WR: idx_q <= idx_q + WIDX_W'(1);
				OP_IDX_CLR, OP_DEC_SETUP: idx_q <= '0;
				OP_ACCEPT, OP_ACCEPT_DEC: begin
					sp_q      <= sp_q + CNT_W'(1);
					res_cnt_q <= res_cnt_q + CNT_W'(1);
				end
				OP_PAR_SET: casc_q <= 1'b0;
				OP_OVF: ovf_q <= 1'b1;
				OP_POP: sp_q <= sp_q - CNT_W'(1);
				OP_LOAD_F: begin
					k_q    <= 3'd1;
					casc_q <= 1'b1;
				end
				OP_NEXT_K: k_q <= k_q + 3'd1;
				OP_EM_NEXT: em_q <= em_q + RES_AW'(1);
				default: ;
			endcase
		end
	end

	// status towards the controller
	always_comb begin
		st.clr_last = clr_q == FRAME_W'(WINDOW - 1);
		st.prim_ok  = req_q.has_primary && seq_in;
		st.copy_ok  = req_q.has_aux && req_q.packet_flags != 8'd0 &&
			req_q.packet_flags <= 8'(COPY_MAX) &&
			req_q.packet_seq >= 32'(req_q.packet_flags) && aux_diff < 32'(WINDOW);
		st.par_ok   = req_q.has_aux && req_q.packet_flags >= 8'(PARITY_MIN) &&
			req_q.packet_flags <= 8'(PARITY_MAX) &&
			req_q.packet_seq >= 32'(spr8) && seq_in;
		st.kn_rd    = kn_rd_q;
		st.pend     = par_rd_q[3];
		st.probe_ok = !ovf_q && !p_w[FRAME_W];
		st.kn_eq    = kn_a_q == kn_rd_q;
		st.kn_a     = kn_a_q;
		st.res_full = res_cnt_q == CNT_W'(MAX_RESULTS);
		st.idx_last = idx_q == WIDX_W'(PAYLOAD_WORDS - 1);
		st.k_last   = k_q == 3'(PROBE_SPAN);
		st.casc     = casc_q;
		st.sp_zero  = sp_q == '0;
		st.ovf      = ovf_q;
		st.res_zero = res_cnt_q == '0;
		st.em_last  = {1'b0, em_q} == res_cnt_q - CNT_W'(1);
	end

	// result word: read data for read requests, notices otherwise
	always_comb begin
		if (req_q.command == CMD_READ) begin
			res_data.result_kind        = 1'b1;
			res_data.frame_number       = seq_f;
			res_data.data_word          = (seq_in && kn_rd_q &&
				32'(req_q.word_index) < 32'(PAYLOAD_WORDS)) ? fst_rd_q : 64'd0;
			res_data.last_result        = 1'b1;
			res_data.recovery_truncated = 1'b0;
		end else begin
			res_data.result_kind        = 1'b0;
			res_data.frame_number       = rl_rd_q;
			res_data.data_word          = 64'd0;
			res_data.last_result        = st.em_last;
			res_data.recovery_truncated = ovf_q;
		end
	end

endmodule

FILE: sv/xpfr_ctrl.sv
// controller state machine: sequences commits, recovery cascade, reads and result output
// depends on xpfr_pkg; drives xpfr_datapath through operation codes

module xpfr_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	input  logic [1:0]           req_cmd,
	output logic                 req_stall,
	input  logic                 out_free,
	output logic                 out_load,
	input  xpfr_pkg::dp_status_t st,
	output xpfr_pkg::dp_op_t     op
);
	import xpfr_pkg::*;

	typedef enum logic [4:0] {
		S_CLR, S_IDLE, S_RD_ISSUE, S_RD_OUT, S_P_CHK, S_P_TST, S_COPY, S_ACC,
		S_A_CHK, S_A_TST, S_Q_TST, S_PWR, S_PSET, S_PROBE, S_KN_A, S_KN_B,
		S_DECIDE, S_DEC_RD, S_DEC_WR, S_NEXT, S_CASC, S_POP, S_EM_RD, S_EM_OUT
	} state_t;

	typedef enum logic [1:0] {
		R_AUX, R_CASC, R_NEXT
	} ret_t;

	state_t state_q, state_d;
	ret_t   ret_q, ret_d;

	always_comb begin
		state_d   = state_q;
		ret_d     = ret_q;
		op        = OP_NONE;
		req_stall = 1'b1;
		out_load  = 1'b0;
		case (state_q)
			S_CLR: begin
				op = OP_CLEAR;
				if (st.clr_last)
					state_d = S_IDLE;
			end
			S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					op = OP_CAPTURE;
					case (req_cmd)
						CMD_COMMIT: state_d = S_P_CHK;
						CMD_READ:   state_d = S_RD_ISSUE;
						default:    state_d = S_IDLE;
					endcase
				end
			end
			S_RD_ISSUE: begin
				op      = OP_RD_ISSUE;
				state_d = S_RD_OUT;
			end
			S_RD_OUT: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_P_CHK: begin
				if (st.prim_ok) begin
					op      = OP_KN_SEQ;
					state_d = S_P_TST;
				end else begin
					state_d = S_A_CHK;
				end
			end
			S_P_TST: begin
				if (!st.kn_rd) begin
					op      = OP_TGT_PRIM;
					ret_d   = R_AUX;
					state_d = S_COPY;
				end else begin
					state_d = S_A_CHK;
				end
			end
			S_COPY: begin
				op = OP_COPY;
				if (st.idx_last)
					state_d = S_ACC;
			end
			S_ACC: begin
				case (ret_q)
					R_AUX: begin
						op      = OP_ACCEPT;
						state_d = S_A_CHK;
					end
					R_CASC: begin
						op      = OP_ACCEPT;
						state_d = S_CASC;
					end
					default: begin
						op      = OP_ACCEPT_DEC;
						state_d = S_NEXT;
					end
				endcase
			end
			S_A_CHK: begin
				if (st.copy_ok) begin
					op      = OP_KN_AUX;
					state_d = S_A_TST;
				end else if (st.par_ok) begin
					op      = OP_PAR_SEQ;
					state_d = S_Q_TST;
				end else begin
					state_d = S_CASC;
				end
			end
			S_A_TST: begin
				if (!st.kn_rd) begin
					op      = OP_TGT_AUX;
					ret_d   = R_CASC;
					state_d = S_COPY;
				end else begin
					state_d = S_CASC;
				end
			end
			S_Q_TST: begin
				if (!st.pend) begin
					op      = OP_IDX_CLR;
					state_d = S_PWR;
				end else begin
					state_d = S_CASC;
				end
			end
			S_PWR: begin
				op = OP_PWR;
				if (st.idx_last)
					state_d = S_PSET;
			end
			S_PSET: begin
				op      = OP_PAR_SET;
				state_d = S_PROBE;
			end
			S_PROBE: begin
				if (st.probe_ok) begin
					op      = OP_PROBE;
					state_d = S_KN_A;
				end else begin
					state_d = S_NEXT;
				end
			end
			S_KN_A: begin
				if (st.pend) begin
					op      = OP_KN_A;
					state_d = S_KN_B;
				end else begin
					state_d = S_NEXT;
				end
			end
			S_KN_B: begin
				op      = OP_KN_B;
				state_d = S_DECIDE;
			end
			S_DECIDE: begin
				if (st.kn_eq) begin
					if (st.kn_a)
						op = OP_PAR_CLR;
					state_d = S_NEXT;
				end else if (st.res_full) begin
					op      = OP_OVF;
					state_d = S_NEXT;
				end else begin
					op      = OP_DEC_SETUP;
					ret_d   = R_NEXT;
					state_d = S_DEC_RD;
				end
			end
			S_DEC_RD: begin
				op      = OP_DEC_RD;
				state_d = S_DEC_WR;
			end
			S_DEC_WR: begin
				op      = OP_DEC_WR;
				state_d = st.idx_last ? S_ACC : S_DEC_RD;
			end
			S_NEXT: begin
				if (st.casc && !st.k_last) begin
					op      = OP_NEXT_K;
					state_d = S_PROBE;
				end else begin
					state_d = S_CASC;
				end
			end
			S_CASC: begin
				if (!st.sp_zero && !st.ovf) begin
					op      = OP_POP;
					state_d = S_POP;
				end else if (st.res_zero) begin
					state_d = S_IDLE;
				end else begin
					state_d = S_EM_RD;
				end
			end
			S_POP: begin
				op      = OP_LOAD_F;
				state_d = S_PROBE;
			end
			S_EM_RD: begin
				op      = OP_EM_RD;
				state_d = S_EM_OUT;
			end
			S_EM_OUT: begin
				if (out_free) begin
					out_load = 1'b1;
					op       = OP_EM_NEXT;
					state_d  = st.em_last ? S_IDLE : S_EM_RD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			ret_q   <= R_AUX;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
		end
	end

endmodule

FILE: sv/xor_parity_fec_frame_recovery_core.sv
// top level of the xor parity fec frame recovery core: controller, datapath, result register
// depends on xpfr_pkg, xpfr_ctrl and xpfr_datapath

// Receives packet payload words and packet headers, keeps a window of 1024 frames of
// 20 64-bit words, and rebuilds lost frames from plain copies and from xor parities of
// frames seq-1 and seq-S. A load request stages one primary and one auxiliary word. A
// commit request stores the primary frame and the copied frame or the parity where they
// are valid, then runs the recovery cascade; each frame that becomes known is reported
// once as a notice, all notices of a commit coming out after the cascade so that the
// truncation flag is right on every one. A read request returns one stored word. Timing
// is set by the walks over the frame and parity stores, word by word for each frame
// copied, parity stored or frame decoded (each decoded word is read and then written
// back), and by the parity probes and the notices sent. After reset the block clears
// the known and parity flags of every frame in the window before it takes the first
// request. Results wait in an output register, so the next request can be taken while
// the last result is still stalled.

module xor_parity_fec_frame_recovery_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  xpfr_pkg::in_req_t  req,
	output logic               res_valid,
	input  logic               res_stall,
	output xpfr_pkg::out_res_t res
);
	import xpfr_pkg::*;

	dp_op_t     op;
	dp_status_t st;
	out_res_t   res_data;
	logic       out_free;
	logic       out_load;

	// result register
	logic       res_valid_q;
	out_res_t   res_q;

	// a result can be loaded when the register is empty or being taken this cycle
	assign out_free = !res_valid_q || !res_stall;

	xpfr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_cmd   (req.command),
		.req_stall (req_stall),
		.out_free  (out_free),
		.out_load  (out_load),
		.st        (st),
		.op        (op)
	);

	xpfr_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.op       (op),
		.st       (st),
		.res_data (res_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	// payload held while stalled, only replaced on a fresh load
	always_ff @(posedge clk) begin
		if (out_load)
			res_q <= res_data;
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule
